FILE: src/refcounted_tag_table_macros.svh
// ---------------------------------------------------------------------------
// refcounted_tag_table assertion macros
// shared property shorthands for the tag table rtl
// ---------------------------------------------------------------------------
`ifndef REFCOUNTED_TAG_TABLE_MACROS_SVH
`define REFCOUNTED_TAG_TABLE_MACROS_SVH

// same-cycle implication, disabled in reset
`define RTT_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled in reset
`define RTT_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: src/rtt_pkg.sv
// ---------------------------------------------------------------------------
// rtt_pkg
// types, codes and defaults shared by the reference counted tag table
// ---------------------------------------------------------------------------
package rtt_pkg;

    localparam int ENTRIES_DEF    = 64;
    localparam int TAG_BITS_DEF   = 16;
    localparam int COUNT_BITS_DEF = 16;

    // fixed widths of the word fields
    localparam int TAG_FIELD_W = 16;
    localparam int CNT_FIELD_W = 16;
    localparam logic [CNT_FIELD_W-1:0] CNT_FIELD_MAX = '1;

    // operation codes
    localparam logic [1:0] OP_ADD    = 2'd0;
    localparam logic [1:0] OP_REMOVE = 2'd1;
    localparam logic [1:0] OP_CLEAR  = 2'd2;
    localparam logic [1:0] OP_QUERY  = 2'd3;

    // event modes
    localparam logic [1:0] MODE_NEVER  = 2'd0;
    localparam logic [1:0] MODE_EDGE   = 2'd1;
    localparam logic [1:0] MODE_ALWAYS = 2'd2;

    // event codes
    localparam logic [1:0] EV_NONE    = 2'd0;
    localparam logic [1:0] EV_ADDED   = 2'd1;
    localparam logic [1:0] EV_REMOVED = 2'd2;

    typedef struct packed {
        logic [1:0]             op;
        logic [TAG_FIELD_W-1:0] tag;
        logic [1:0]             mode;
        logic                   suppress_event;
    } t_in_word;

    typedef struct packed {
        logic [1:0]             event_res;
        logic                   changed;
        logic                   present;
        logic [CNT_FIELD_W-1:0] count;
        logic                   table_full;
    } t_out_word;

    // classified command handed from front to back (tag travels beside it)
    typedef struct packed {
        logic [1:0] op;
        logic [1:0] mode;
        logic       suppress_event;
        logic       tag_zero;
    } t_cmd;

endpackage

FILE: src/rtt_front.sv
// ---------------------------------------------------------------------------
// rtt_front
// accepts input words, folds the tag to the table width, flags tag zero
// and holds the classified commands in a two-entry queue
// ---------------------------------------------------------------------------
module rtt_front import rtt_pkg::*; #(
    parameter int TAG_BITS = TAG_BITS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  t_in_word            i_in_data,
    output logic                o_cmd_valid,
    input  logic                i_cmd_pop,
    output t_cmd                o_cmd,
    output logic [TAG_BITS-1:0] o_cmd_tag
);

    localparam int WIDE_W = TAG_BITS + TAG_FIELD_W;

    logic [WIDE_W-1:0]   w_tag_wide;
    logic [TAG_BITS-1:0] w_tag;
    t_cmd                w_cmd;
    logic                w_push;

    t_cmd                r_q_cmd [2];
    logic [TAG_BITS-1:0] r_q_tag [2];
    logic                r_wp;
    logic                r_rp;
    logic [1:0]          r_cnt;

    // tag taken modulo 2^TAG_BITS, zero extended when the table is wider
    assign w_tag_wide = {{TAG_BITS{1'b0}}, i_in_data.tag};
    assign w_tag      = w_tag_wide[TAG_BITS-1:0];

    always_comb begin
        w_cmd.op             = i_in_data.op;
        w_cmd.mode           = i_in_data.mode;
        w_cmd.suppress_event = i_in_data.suppress_event;
        w_cmd.tag_zero       = (w_tag == '0);
    end

    assign o_in_ready  = (r_cnt != 2'd2);
    assign w_push      = i_in_valid && o_in_ready;
    assign o_cmd_valid = (r_cnt != 2'd0);
    assign o_cmd       = r_q_cmd[r_rp];
    assign o_cmd_tag   = r_q_tag[r_rp];

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q_cmd[r_wp] <= w_cmd;
            r_q_tag[r_wp] <= w_tag;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) begin
                r_wp <= ~r_wp;
            end
            if (i_cmd_pop) begin
                r_rp <= ~r_rp;
            end
            if (w_push && !i_cmd_pop) begin
                r_cnt <= r_cnt + 2'd1;
            end else if (!w_push && i_cmd_pop) begin
                r_cnt <= r_cnt - 2'd1;
            end
        end
    end

endmodule

FILE: src/rtt_back.sv
// ---------------------------------------------------------------------------
// rtt_back
// tag cam lookup, count update and result register
// ---------------------------------------------------------------------------
`include "refcounted_tag_table_macros.svh"

module rtt_back import rtt_pkg::*; #(
    parameter int ENTRIES    = ENTRIES_DEF,
    parameter int TAG_BITS   = TAG_BITS_DEF,
    parameter int COUNT_BITS = COUNT_BITS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cmd_valid,
    output logic                o_cmd_pop,
    input  t_cmd                i_cmd,
    input  logic [TAG_BITS-1:0] i_cmd_tag,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output t_out_word           o_out_data
);

    localparam int IW     = $clog2(ENTRIES);
    localparam int CW     = COUNT_BITS;
    localparam int WIDE_W = CW + CNT_FIELD_W;
    localparam logic [CW-1:0] CNT_MAX = '1;
    localparam logic [CW-1:0] CNT_ONE = CW'(1);

    localparam logic ST_LOOK = 1'b0;
    localparam logic ST_EXEC = 1'b1;

    // table state
    logic [ENTRIES-1:0]  r_valid;
    logic [TAG_BITS-1:0] r_tags   [ENTRIES];
    logic [CW-1:0]       r_counts [ENTRIES];

    logic                r_state;
    t_cmd                r_cmd;
    logic [TAG_BITS-1:0] r_tag;
    logic                r_hit;
    logic [IW-1:0]       r_hit_idx;
    logic                r_free;
    logic [IW-1:0]       r_free_idx;
    logic [CW-1:0]       r_cnt_rd;
    logic                r_out_valid;
    t_out_word           r_out_data;

    logic [ENTRIES-1:0]  w_match;
    logic [IW-1:0]       w_hit_idx;
    logic [IW-1:0]       w_free_idx;
    logic                w_pop;
    logic                w_exec;

    logic [IW-1:0]       w_tgt;
    logic [CW-1:0]       w_c_old;
    logic [CW-1:0]       w_cnt_new;
    logic [CW-1:0]       w_cnt_rep;
    logic                w_wr_cnt;
    logic                w_wr_tag;
    logic                w_set_valid;
    logic                w_clr_valid;
    logic [WIDE_W-1:0]   w_cnt_wide;
    t_out_word           w_res;

    // parallel compare against every live entry
    always_comb begin
        for (int i = 0; i < ENTRIES; i++) begin
            w_match[i] = r_valid[i] && (r_tags[i] == i_cmd_tag);
        end
    end

    // tags are unique, so or-ing the indices of matching entries encodes the hit
    always_comb begin
        w_hit_idx = '0;
        for (int i = 0; i < ENTRIES; i++) begin
            if (w_match[i]) begin
                w_hit_idx = w_hit_idx | IW'(i);
            end
        end
    end

    // lowest free entry
    always_comb begin
        w_free_idx = '0;
        for (int i = ENTRIES - 1; i >= 0; i--) begin
            if (!r_valid[i]) begin
                w_free_idx = IW'(i);
            end
        end
    end

    assign w_pop     = (r_state == ST_LOOK) && i_cmd_valid;
    assign o_cmd_pop = w_pop;
    assign w_exec    = (r_state == ST_EXEC) && (!r_out_valid || i_out_ready);

    always_ff @(posedge i_clk) begin
        if (w_pop) begin
            r_cmd      <= i_cmd;
            r_tag      <= i_cmd_tag;
            r_hit      <= |w_match;
            r_hit_idx  <= w_hit_idx;
            r_free     <= ~&r_valid;
            r_free_idx <= w_free_idx;
            r_cnt_rd   <= r_counts[w_hit_idx];
        end
    end

    always_comb begin
        w_res       = '0;
        w_tgt       = r_hit_idx;
        w_c_old     = r_hit ? r_cnt_rd : '0;
        w_cnt_new   = r_cnt_rd;
        w_cnt_rep   = '0;
        w_wr_cnt    = 1'b0;
        w_wr_tag    = 1'b0;
        w_set_valid = 1'b0;
        w_clr_valid = 1'b0;
        unique case (r_cmd.op)
            OP_ADD: begin
                if (!r_cmd.tag_zero) begin
                    if (!r_hit && !r_free) begin
                        w_res.table_full = 1'b1;
                    end else begin
                        w_tgt         = r_hit ? r_hit_idx : r_free_idx;
                        w_cnt_new     = (w_c_old == CNT_MAX) ? w_c_old : w_c_old + CNT_ONE;
                        w_wr_cnt      = 1'b1;
                        w_wr_tag      = !r_hit;
                        w_set_valid   = !r_hit;
                        w_res.changed = 1'b1;
                        w_cnt_rep     = w_cnt_new;
                        if (r_cmd.mode == MODE_ALWAYS ||
                            (r_cmd.mode == MODE_EDGE && w_cnt_new == CNT_ONE)) begin
                            w_res.event_res = EV_ADDED;
                        end
                    end
                end
            end
            OP_REMOVE: begin
                if (r_hit) begin
                    w_cnt_new     = r_cnt_rd - CNT_ONE;
                    w_wr_cnt      = 1'b1;
                    w_clr_valid   = (w_cnt_new == '0);
                    w_res.changed = 1'b1;
                    w_cnt_rep     = w_cnt_new;
                    if (r_cmd.mode == MODE_ALWAYS ||
                        (r_cmd.mode == MODE_EDGE && w_cnt_new == '0)) begin
                        w_res.event_res = EV_REMOVED;
                    end
                end
            end
            OP_CLEAR: begin
                if (r_hit) begin
                    w_clr_valid   = 1'b1;
                    w_res.changed = 1'b1;
                    if (!r_cmd.suppress_event) begin
                        w_res.event_res = EV_REMOVED;
                    end
                end
            end
            OP_QUERY: begin
                if (r_hit) begin
                    w_cnt_rep = r_cnt_rd;
                end
            end
            default: begin
            end
        endcase
        // count field clamps when the stored count is wider than the word
        w_cnt_wide    = {{CNT_FIELD_W{1'b0}}, w_cnt_rep};
        w_res.present = (w_cnt_rep != '0);
        w_res.count   = (w_cnt_wide > WIDE_W'(CNT_FIELD_MAX)) ? CNT_FIELD_MAX
                                                              : w_cnt_wide[CNT_FIELD_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (w_exec && w_wr_cnt) begin
            r_counts[w_tgt] <= w_cnt_new;
        end
        if (w_exec && w_wr_tag) begin
            r_tags[w_tgt] <= r_tag;
        end
        if (w_exec) begin
            r_out_data <= w_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid     <= '0;
            r_state     <= ST_LOOK;
            r_out_valid <= 1'b0;
        end else begin
            if (w_exec && w_set_valid) begin
                r_valid[w_tgt] <= 1'b1;
            end else if (w_exec && w_clr_valid) begin
                r_valid[w_tgt] <= 1'b0;
            end
            unique case (r_state)
                ST_LOOK: begin
                    if (w_pop) begin
                        r_state <= ST_EXEC;
                    end
                end
                ST_EXEC: begin
                    if (w_exec) begin
                        r_state <= ST_LOOK;
                    end
                end
                default: begin
                    r_state <= ST_LOOK;
                end
            endcase
            if (w_exec) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    `RTT_ASSERT_IMP(a_match_unique, i_clk, i_rst_n, w_pop, $onehot0(w_match), "tag found in more than one entry")
    `RTT_ASSERT_IMP(a_full_alone, i_clk, i_rst_n, r_out_valid && r_out_data.table_full, !r_out_data.changed && r_out_data.event_res == EV_NONE && r_out_data.count == '0, "dropped add reports more than full")
    `RTT_ASSERT_IMP(a_present_count, i_clk, i_rst_n, r_out_valid, r_out_data.present == (r_out_data.count != '0), "present disagrees with count")
    `RTT_ASSERT_NXT(a_add_live, i_clk, i_rst_n, w_exec && r_cmd.op == OP_ADD && w_res.changed, r_valid[$past(w_tgt)], "entry not live after add")

endmodule

FILE: src/refcounted_tag_table.sv
// path: front queue, then back end lookup registers, then result register
// order: the back end takes no new word until the last is written, set by the
//   lookup then write sequence on the tag cam and the count memory
// reset: clears entry valid bits, queue, sequencer and output valid; tags and
//   counts are left as they are and need no clearing pass
// ---------------------------------------------------------------------------
// refcounted_tag_table
// associative table of tags with reference counts, add / remove / clear /
// query, with added and removed events
// ---------------------------------------------------------------------------
module refcounted_tag_table import rtt_pkg::*; #(
    parameter int ENTRIES    = ENTRIES_DEF,
    parameter int TAG_BITS   = TAG_BITS_DEF,
    parameter int COUNT_BITS = COUNT_BITS_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    // input words
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_word  i_in_data,
    // result words
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_word o_out_data
);

    // classified command crossing the queue
    logic                w_cmd_valid;
    logic                w_cmd_pop;
    t_cmd                w_cmd;
    logic [TAG_BITS-1:0] w_cmd_tag;

    // front: takes words whenever its two-entry queue has room, so input
    // keeps flowing while the back end waits on a stalled result
    rtt_front #(
        .TAG_BITS (TAG_BITS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_cmd_valid (w_cmd_valid),
        .i_cmd_pop   (w_cmd_pop),
        .o_cmd       (w_cmd),
        .o_cmd_tag   (w_cmd_tag)
    );

    // back: a cam lookup and count read state, then an update state writing
    // into the result register; it holds in update while the result waits
    rtt_back #(
        .ENTRIES    (ENTRIES),
        .TAG_BITS   (TAG_BITS),
        .COUNT_BITS (COUNT_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (w_cmd_valid),
        .o_cmd_pop   (w_cmd_pop),
        .i_cmd       (w_cmd),
        .i_cmd_tag   (w_cmd_tag),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

endmodule
